// File: sv/assert_macros.svh
// Assertion macros shared by the additive hash counting table RTL.
// The module that uses them must have a clock named clk and a reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AHT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aht: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define AHT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aht: next-cycle check failed");

`endif

// File: sv/aht_pkg.sv
// Package for the additive hash counting table: field widths, opcodes,
// reset values and parameter defaults. No dependencies.
package aht_pkg;

  localparam int OPCODE_W    = 2;
  localparam int CHAR_W      = 8;
  localparam int INDEX_W     = 10;
  localparam int COUNT_OUT_W = 16;
  localparam int NZ_W        = 11;
  localparam int SIZE_W      = 11;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_COUNT_WIDTH = 16;

  localparam logic [OPCODE_W-1:0] OP_KEY   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

endpackage

// File: sv/aht_if.sv
// Channel interfaces of the additive hash counting table: request, result
// and configuration write. Depends on aht_pkg.
interface aht_req_if;
  logic                          valid;
  logic                          ready;
  logic [aht_pkg::OPCODE_W-1:0]  opcode;
  logic [aht_pkg::CHAR_W-1:0]    key_char;
  logic                          key_last;
  logic                          count_down;
  logic [aht_pkg::INDEX_W-1:0]   read_index;

  modport source (output valid, opcode, key_char, key_last, count_down, read_index,
                  input ready);
  modport sink   (input valid, opcode, key_char, key_last, count_down, read_index,
                  output ready);
endinterface

interface aht_res_if;
  logic                                valid;
  logic                                ready;
  logic [aht_pkg::INDEX_W-1:0]         bucket;
  logic signed [aht_pkg::COUNT_OUT_W-1:0] bucket_count;
  logic [aht_pkg::NZ_W-1:0]            nonzero_buckets;
  logic                                saturated;

  modport source (output valid, bucket, bucket_count, nonzero_buckets, saturated,
                  input ready);
  modport sink   (input valid, bucket, bucket_count, nonzero_buckets, saturated,
                  output ready);
endinterface

interface aht_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [aht_pkg::SIZE_W-1:0]  table_size;

  modport source (output valid, table_size, input ready);
  modport sink   (input valid, table_size, output ready);
endinterface

// File: sv/aht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aht_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/aht_rem.sv
// Iterative remainder unit: one restoring compare-subtract step per cycle,
// one dividend bit per step. Depends on assert_macros.svh.
module aht_rem #(
  parameter int SUM_W = 11,
  parameter int DIV_W = 11,
  parameter int REM_W = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [REM_W-1:0] rem
);

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] q;
  logic [DIV_W-1:0] d;
  logic [DIV_W-1:0] r;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic [DIV_W-1:0] r_next;

  always_comb begin
    shifted = {r, q[SUM_W-1]};
    diff    = shifted - {1'b0, d};
    // keep the shifted value when the subtract borrows
    r_next  = diff[DIV_W] ? shifted[DIV_W-1:0] : diff[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q    <= dividend;
        d    <= divisor;
        r    <= '0;
        cnt  <= CNT_W'(SUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        r   <= r_next;
        q   <= q << 1;
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = r[REM_W-1:0];

  `AHT_IMPLIES(rem_below_divisor, busy || done, r < d)

endmodule

// File: sv/additive_hash_counting_table.sv
// Channel   Dir  Payload                                               Accept
// key_in    in   opcode, key_char, key_last, count_down, read_index    valid & ready
// result    out  bucket, bucket_count, nonzero_buckets, saturated      valid & ready
// cfg       in   table_size                                            valid & ready
//
// Key character: set by the bit-serial remainder unit, one dividend bit per step;
//   the last character of a key adds the counter read-modify-write and the
//   result load. Read: a RAM read and the result load.
// Clear and reset: a clearing pass over all TABLE_DEPTH entries, one entry per cycle,
//   with key_in not ready; cfg is always ready.
// A result waits in the output register; a full register holds the next result.
// Depends on aht_pkg, aht_if, aht_ram, aht_rem and assert_macros.svh.
module additive_hash_counting_table #(
  parameter int TABLE_DEPTH = aht_pkg::DEF_TABLE_DEPTH,
  parameter int COUNT_WIDTH = aht_pkg::DEF_COUNT_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  aht_req_if.sink   key_in,
  aht_res_if.source result,
  aht_cfg_if.sink   cfg
);

  import aht_pkg::*;
  `include "assert_macros.svh"

  localparam int KW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = $clog2(TABLE_DEPTH + 255);

  localparam logic signed [COUNT_WIDTH-1:0] CMAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CMIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MOD   = 6'b000100,
    S_UPD   = 6'b001000,
    S_READ  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;

  logic [SIZE_W-1:0]  table_size;
  logic [KW-1:0]      key_sum;
  logic [DW-1:0]      nonzero_total;
  logic [KW-1:0]      clr_addr;
  logic               last_q;
  logic               down_q;
  logic [KW-1:0]      bucket_q;
  logic [INDEX_W-1:0] read_idx_q;
  logic               read_ok_q;

  logic [INDEX_W-1:0]            res_bucket;
  logic signed [COUNT_OUT_W-1:0] res_count;
  logic [NZ_W-1:0]               res_nz;
  logic                          res_sat;

  logic                          out_valid;
  logic [INDEX_W-1:0]            out_bucket;
  logic signed [COUNT_OUT_W-1:0] out_count;
  logic [NZ_W-1:0]               out_nz;
  logic                          out_sat;

  logic [DW-1:0] eff_size;
  logic          req_take;
  logic          clear_take;
  logic          out_load;
  logic          rem_start;
  logic [SW-1:0] rem_dividend;
  logic          rem_done;
  logic [KW-1:0] rem_value;

  logic                          ram_we;
  logic [KW-1:0]                 ram_waddr;
  logic [COUNT_WIDTH-1:0]        ram_wdata;
  logic [KW-1:0]                 ram_raddr;
  logic [COUNT_WIDTH-1:0]        ram_rdata;

  logic signed [COUNT_WIDTH-1:0] old_count;
  logic signed [COUNT_WIDTH-1:0] upd_count;
  logic                          upd_sat;
  logic [DW-1:0]                 nz_next;

  assign key_in.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign req_take     = key_in.valid && key_in.ready;
  assign clear_take   = req_take && (key_in.opcode == OP_CLEAR);
  assign out_load     = (state == S_EMIT) && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_RESET;
    end else if (cfg.valid) begin
      table_size <= cfg.table_size;
    end
  end

  // clamp the modulus to 1 .. TABLE_DEPTH
  always_comb begin
    if (table_size == '0) begin
      eff_size = DW'(1);
    end else if (32'(table_size) > TABLE_DEPTH) begin
      eff_size = DW'(TABLE_DEPTH);
    end else begin
      eff_size = DW'(table_size);
    end
  end

  assign rem_start    = req_take && (key_in.opcode == OP_KEY);
  assign rem_dividend = SW'(key_sum) + SW'(key_in.key_char);

  aht_rem #(
    .SUM_W (SW),
    .DIV_W (DW),
    .REM_W (KW)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (eff_size),
    .done     (rem_done),
    .rem      (rem_value)
  );

  always_comb begin
    case (state)
      S_IDLE:  ram_raddr = KW'(key_in.read_index);
      S_MOD:   ram_raddr = rem_value;
      default: ram_raddr = bucket_q;
    endcase
  end

  // counter update: saturate at the signed limits
  always_comb begin
    old_count = signed'(ram_rdata);
    upd_sat   = 1'b0;
    if (down_q) begin
      if (old_count == CMIN) begin
        upd_count = old_count;
        upd_sat   = 1'b1;
      end else begin
        upd_count = old_count - COUNT_WIDTH'(1);
      end
    end else begin
      if (old_count == CMAX) begin
        upd_count = old_count;
        upd_sat   = 1'b1;
      end else begin
        upd_count = old_count + COUNT_WIDTH'(1);
      end
    end
    nz_next = nonzero_total;
    if (old_count == '0 && upd_count != '0) begin
      nz_next = nonzero_total + 1'b1;
    end else if (old_count != '0 && upd_count == '0) begin
      nz_next = nonzero_total - 1'b1;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = bucket_q;
    ram_wdata = upd_count;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_UPD: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  aht_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      key_sum       <= '0;
      nonzero_total <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (clr_addr == KW'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (req_take) begin
            last_q     <= key_in.key_last;
            down_q     <= key_in.count_down;
            read_idx_q <= key_in.read_index;
            read_ok_q  <= (32'(key_in.read_index) < TABLE_DEPTH);
            case (key_in.opcode)
              OP_KEY: begin
                state <= S_MOD;
              end
              OP_CLEAR: begin
                clr_addr      <= '0;
                nonzero_total <= '0;
                state         <= S_CLEAR;
              end
              OP_READ: begin
                state <= S_READ;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_MOD: begin
          if (rem_done) begin
            bucket_q <= rem_value;
            if (last_q) begin
              key_sum <= '0;
              state   <= S_UPD;
            end else begin
              key_sum <= rem_value;
              state   <= S_IDLE;
            end
          end
        end
        S_UPD: begin
          nonzero_total <= nz_next;
          res_bucket    <= INDEX_W'(bucket_q);
          res_count     <= COUNT_OUT_W'(upd_count);
          res_nz        <= NZ_W'(nz_next);
          res_sat       <= upd_sat;
          state         <= S_EMIT;
        end
        S_READ: begin
          res_bucket <= read_idx_q;
          res_count  <= read_ok_q ? COUNT_OUT_W'(old_count) : '0;
          res_nz     <= NZ_W'(nonzero_total);
          res_sat    <= 1'b0;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register: load when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bucket <= res_bucket;
      out_count  <= res_count;
      out_nz     <= res_nz;
      out_sat    <= res_sat;
    end
  end

  assign result.valid           = out_valid;
  assign result.bucket          = out_bucket;
  assign result.bucket_count    = out_count;
  assign result.nonzero_buckets = out_nz;
  assign result.saturated       = out_sat;

  `AHT_IMPLIES(nz_in_range, 1'b1, 32'(nonzero_total) <= TABLE_DEPTH)
  `AHT_NEXT(clear_drops_nz, clear_take, nonzero_total == '0 && state == S_CLEAR)
  `AHT_IMPLIES(sat_holds_count, state == S_UPD && upd_sat, upd_count == old_count)
  `AHT_NEXT(emit_loads_out, out_load, out_valid && state == S_IDLE)

endmodule

// File: bench/additive_hash_counting_table_tb.sv
// Self-checking testbench for additive_hash_counting_table: directed and random requests
// against a bucket-count tracker, with idling and stalling on both channels.
// Depends on aht_pkg, aht_if and the block's RTL.
module additive_hash_counting_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aht_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int BUCKETS = DEF_TABLE_DEPTH;
  localparam int COUNTER_BITS = DEF_COUNT_WIDTH;
  localparam int COUNT_MAX = (1 << (COUNTER_BITS - 1)) - 1;
  localparam int COUNT_MIN = -(1 << (COUNTER_BITS - 1));
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  // Covers a full clearing pass or one key character still in flight.
  localparam int SETTLE_CYCLES = BUCKETS + 64;
  localparam int TAIL_CYCLES = 40;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_REQUESTS = 1050;
  localparam int PHASES = 12;

  typedef struct {
    logic [OPCODE_W-1:0] opcode;
    logic [CHAR_W-1:0]   key_char;
    logic                key_last;
    logic                count_down;
    logic [INDEX_W-1:0]  read_index;
  } request_t;

  typedef struct {
    logic [INDEX_W-1:0]            bucket;
    logic signed [COUNT_OUT_W-1:0] count;
    logic [NZ_W-1:0]               nonzero;
    logic                          saturated;
  } bucket_report_t;

  class hash_table_checker;
    int counts[BUCKETS];
    int key_sum;
    int nonzero;
    logic [SIZE_W-1:0] table_size;
    bucket_report_t awaited[$];
    int errors;

    function new();
      foreach (counts[i]) counts[i] = 0;
      key_sum = 0;
      nonzero = 0;
      table_size = SIZE_RESET;
      errors = 0;
    endfunction

    function int hash_modulus();
      if (table_size == 0) return 1;
      if (int'(table_size) > BUCKETS) return BUCKETS;
      return int'(table_size);
    endfunction

    function void accept_request(request_t r);
      int old_count;
      int new_count;
      bucket_report_t rep;
      rep.saturated = 1'b0;
      case (r.opcode)
        OP_KEY: begin
          key_sum = (key_sum + int'(r.key_char)) % hash_modulus();
          if (r.key_last) begin
            old_count = counts[key_sum];
            new_count = r.count_down ? old_count - 1 : old_count + 1;
            if (new_count > COUNT_MAX) begin
              new_count = COUNT_MAX;
              rep.saturated = 1'b1;
            end
            if (new_count < COUNT_MIN) begin
              new_count = COUNT_MIN;
              rep.saturated = 1'b1;
            end
            if (old_count == 0 && new_count != 0) nonzero++;
            else if (old_count != 0 && new_count == 0) nonzero--;
            counts[key_sum] = new_count;
            rep.bucket = INDEX_W'(key_sum);
            rep.count = COUNT_OUT_W'(new_count);
            rep.nonzero = NZ_W'(nonzero);
            awaited.push_back(rep);
            key_sum = 0;
          end
        end
        OP_CLEAR: begin
          foreach (counts[i]) counts[i] = 0;
          nonzero = 0;
        end
        OP_READ: begin
          rep.bucket = r.read_index;
          rep.count = (int'(r.read_index) < BUCKETS) ? COUNT_OUT_W'(counts[r.read_index]) : '0;
          rep.nonzero = NZ_W'(nonzero);
          awaited.push_back(rep);
        end
        default: begin
        end
      endcase
    endfunction

    task report(string what);
      if (errors < 100) $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_report(bucket_report_t got);
      bucket_report_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result for bucket %0d with nothing outstanding", got.bucket));
        return;
      end
      want = awaited.pop_front();
      if (got.bucket !== want.bucket)
        report($sformatf("bucket: got %0d, want %0d", got.bucket, want.bucket));
      if (got.count !== want.count)
        report($sformatf("bucket_count of bucket %0d: got %0d, want %0d",
                         want.bucket, got.count, want.count));
      if (got.nonzero !== want.nonzero)
        report($sformatf("nonzero_buckets: got %0d, want %0d", got.nonzero, want.nonzero));
      if (got.saturated !== want.saturated)
        report($sformatf("saturated of bucket %0d: got %b, want %b",
                         want.bucket, got.saturated, want.saturated));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int quiet_cycles = 0;
  hash_table_checker table_model;

  aht_req_if key_ch();
  aht_res_if res_ch();
  aht_cfg_if cfg_ch();

  additive_hash_counting_table #(
    .TABLE_DEPTH(BUCKETS),
    .COUNT_WIDTH(COUNTER_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .key_in(key_ch),
    .result(res_ch),
    .cfg(cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Result side: check each accepted result, then pick the next ready level.
  always @(posedge clk) begin
    bucket_report_t seen;
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen.bucket = res_ch.bucket;
      seen.count = res_ch.bucket_count;
      seen.nonzero = res_ch.nonzero_buckets;
      seen.saturated = res_ch.saturated;
      table_model.check_report(seen);
    end
    res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(logic [OPCODE_W-1:0] opcode, logic [CHAR_W-1:0] key_char,
                              logic key_last, logic count_down,
                              logic [INDEX_W-1:0] read_index);
    request_t r;
    r.opcode = opcode;
    r.key_char = key_char;
    r.key_last = key_last;
    r.count_down = count_down;
    r.read_index = read_index;
    while ($urandom_range(99) < src_idle_pct) begin
      key_ch.valid <= 1'b0;
      @(posedge clk);
    end
    key_ch.valid <= 1'b1;
    key_ch.opcode <= r.opcode;
    key_ch.key_char <= r.key_char;
    key_ch.key_last <= r.key_last;
    key_ch.count_down <= r.count_down;
    key_ch.read_index <= r.read_index;
    do @(posedge clk); while (!key_ch.ready);
    table_model.accept_request(r);
  endtask

  task automatic wait_drained(int extra_cycles);
    key_ch.valid <= 1'b0;
    while (table_model.awaited.size() != 0) @(posedge clk);
    repeat (extra_cycles) @(posedge clk);
  endtask

  // Hold off until the block is idle, then write the register.
  task automatic write_table_size(logic [SIZE_W-1:0] size);
    wait_drained(SETTLE_CYCLES);
    cfg_ch.valid <= 1'b1;
    cfg_ch.table_size <= size;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    table_model.table_size = size;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 71; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 71; end
      default: begin src_idle_pct = 15; sink_stall_pct = 15; end
    endcase
  endtask

  task automatic run_random_phase(int requests);
    int sent;
    int pick;
    int chars_left;
    int up_pct;
    logic down;
    logic [INDEX_W-1:0] idx;
    sent = 0;
    chars_left = 0;
    down = 1'b0;
    up_pct = $urandom_range(20, 80);
    while (sent < requests) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        idx = $urandom_range(1) ? INDEX_W'($urandom_range(table_model.hash_modulus() - 1))
                                : INDEX_W'($urandom_range(1023));
        send_request(OP_READ, CHAR_W'($urandom), 1'($urandom), 1'($urandom), idx);
        sent++;
      end else if (pick < 9) begin
        send_request(OP_CLEAR, CHAR_W'($urandom), 1'($urandom), 1'($urandom),
                     INDEX_W'($urandom));
        sent++;
      end else if (pick < 11) begin
        // ignored by the block, not counted
        send_request(OP_UNUSED, CHAR_W'($urandom), 1'($urandom), 1'($urandom),
                     INDEX_W'($urandom));
      end else begin
        if (chars_left == 0) begin
          chars_left = $urandom_range(1, 5);
          down = ($urandom_range(99) >= up_pct);
        end
        chars_left--;
        send_request(OP_KEY, CHAR_W'($urandom_range(255)), chars_left == 0, down,
                     INDEX_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] phase_sizes[PHASES];
    table_model = new();
    phase_sizes = '{11'd1, 11'd2, 11'd1024, 11'd3, 11'd2047, 11'd5, 11'd16, 11'd1023,
                    11'd0, 11'd255, 11'd1000, 11'd1};
    phase_sizes[PHASES-1] = SIZE_W'($urandom_range(1, 2047));
    rst <= 1'b1;
    key_ch.valid <= 1'b0;
    key_ch.opcode <= OP_KEY;
    key_ch.key_char <= '0;
    key_ch.key_last <= 1'b0;
    key_ch.count_down <= 1'b0;
    key_ch.read_index <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.table_size <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: oversized table, empty key, reads at the edges, ignored opcode, clear.
    set_idling(0);
    write_table_size(11'd2047);
    send_request(OP_KEY, 8'd0, 1'b1, 1'b0, 10'd0);
    send_request(OP_KEY, 8'd255, 1'b0, 1'b0, 10'd0);
    send_request(OP_KEY, 8'd1, 1'b1, 1'b1, 10'd0);
    send_request(OP_READ, 8'd0, 1'b0, 1'b0, 10'd1023);
    send_request(OP_READ, 8'd0, 1'b0, 1'b0, 10'd256);
    send_request(OP_UNUSED, 8'hff, 1'b1, 1'b1, 10'h3ff);
    send_request(OP_CLEAR, 8'h00, 1'b0, 1'b0, 10'd0);
    send_request(OP_READ, 8'hff, 1'b1, 1'b1, 10'd256);
    // Leave this key open across the size change.
    send_request(OP_KEY, 8'd200, 1'b0, 1'b0, 10'd0);
    write_table_size(11'd0);
    send_request(OP_KEY, 8'd77, 1'b1, 1'b0, 10'd0);
    // Count bucket 0 up and read bucket 1023, then count bucket 0 below zero from clear.
    repeat (7) send_request(OP_KEY, CHAR_W'($urandom), 1'b1, 1'b0, 10'd0);
    send_request(OP_READ, 8'd0, 1'b0, 1'b0, 10'd1023);
    send_request(OP_CLEAR, 8'd0, 1'b0, 1'b0, 10'd0);
    repeat (9) send_request(OP_KEY, CHAR_W'($urandom), 1'b1, 1'b1, 10'd0);

    for (int p = 0; p < PHASES; p++) begin
      write_table_size(phase_sizes[p]);
      set_idling(p % 4);
      run_random_phase(RANDOM_REQUESTS / PHASES);
    end

    wait_drained(TAIL_CYCLES);
    if (table_model.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
